// ===== hdl/iis_pkg.sv =====
// shared constants, types and register codes for the integral image stream
// no dependencies; every other file refers to it by scoped names
package iis_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W  = 8;
  localparam int SUM_W  = 28;
  localparam int CFG_W  = 11;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int RUN_W = $clog2(MAX_WIDTH * 255 + 1);

  localparam int COL_CMP_W = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam int ROW_CMP_W = (CFG_W > ROW_W + 1) ? CFG_W : ROW_W + 1;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(1024);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(1024);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             first_row;
    logic [RUN_W-1:0] run_sum;
    logic             row_end;
    logic             frame_end;
  } job_t;

endpackage

// ===== hdl/iis_if.sv =====
// valid/ready channel interfaces for pixel words and area sum words
// depends on iis_pkg for field widths
interface iis_pix_if;
  logic                      valid;
  logic                      ready;
  logic [iis_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface iis_sum_if;
  logic                      valid;
  logic                      ready;
  logic [iis_pkg::SUM_W-1:0] area_sum;
  logic                      row_end;
  logic                      frame_end;

  modport source (output valid, output area_sum, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input area_sum, input row_end, input frame_end,
                output ready);
endinterface

// ===== hdl/iis_regs.sv =====
// apb-style register file holding frame width and height
// depends on iis_pkg
module iis_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [iis_pkg::ADDR_W-1:0] paddr,
  input  logic [iis_pkg::DATA_W-1:0] pwdata,
  output logic [iis_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output iis_pkg::cfg_t              cfg
);

  logic [iis_pkg::CFG_W-1:0] width_r;
  logic [iis_pkg::CFG_W-1:0] height_r;
  iis_pkg::reg_idx_t         idx;
  logic                      wr_en;

  assign idx    = iis_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= iis_pkg::WIDTH_RST;
      height_r <= iis_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      case (idx)
        iis_pkg::REG_FRAME_WIDTH:  width_r  <= pwdata[iis_pkg::CFG_W-1:0];
        iis_pkg::REG_FRAME_HEIGHT: height_r <= pwdata[iis_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      iis_pkg::REG_FRAME_WIDTH:  prdata = iis_pkg::DATA_W'(width_r);
      iis_pkg::REG_FRAME_HEIGHT: prdata = iis_pkg::DATA_W'(height_r);
      default:                   prdata = '0;
    endcase
  end

  assign cfg.frame_width  = width_r;
  assign cfg.frame_height = height_r;

endmodule

// ===== hdl/iis_front.sv =====
// front end: accepts pixel words, tracks position and the running row sum
// depends on iis_pkg, iis_if
module iis_front (
  input  logic          clk,
  input  logic          rst_n,
  input  iis_pkg::cfg_t cfg,
  iis_pix_if.sink       in_pix,
  input  logic          q_ready,
  output logic          q_push,
  output iis_pkg::job_t q_job
);

  logic [iis_pkg::COL_W-1:0]     col_r;
  logic [iis_pkg::COL_W-1:0]     col_nxt;
  logic [iis_pkg::ROW_W-1:0]     row_r;
  logic [iis_pkg::ROW_W-1:0]     row_nxt;
  logic [iis_pkg::RUN_W-1:0]     run_r;
  logic [iis_pkg::RUN_W-1:0]     run_nxt;
  logic [iis_pkg::RUN_W-1:0]     run_sum;
  logic [iis_pkg::COL_CMP_W-1:0] w_ext;
  logic [iis_pkg::ROW_CMP_W-1:0] h_ext;
  logic [iis_pkg::COL_W-1:0]     w_last;
  logic [iis_pkg::ROW_W-1:0]     h_last;
  logic                          row_end;
  logic                          frame_end;

  // clamp width and height to 1..max, as last index
  always_comb begin
    w_ext = iis_pkg::COL_CMP_W'(cfg.frame_width);
    h_ext = iis_pkg::ROW_CMP_W'(cfg.frame_height);
    if (w_ext == '0) begin
      w_last = '0;
    end else if (w_ext > iis_pkg::COL_CMP_W'(iis_pkg::MAX_WIDTH)) begin
      w_last = iis_pkg::COL_W'(iis_pkg::MAX_WIDTH - 1);
    end else begin
      w_last = iis_pkg::COL_W'(w_ext - 1'b1);
    end
    if (h_ext == '0) begin
      h_last = '0;
    end else if (h_ext > iis_pkg::ROW_CMP_W'(iis_pkg::MAX_HEIGHT)) begin
      h_last = iis_pkg::ROW_W'(iis_pkg::MAX_HEIGHT - 1);
    end else begin
      h_last = iis_pkg::ROW_W'(h_ext - 1'b1);
    end
  end

  assign in_pix.ready = q_ready;
  assign q_push       = in_pix.valid && q_ready;

  assign run_sum   = run_r + iis_pkg::RUN_W'(in_pix.pixel);
  assign row_end   = col_r >= w_last;
  assign frame_end = row_end && (row_r >= h_last);

  assign q_job.col       = col_r;
  assign q_job.first_row = (row_r == '0);
  assign q_job.run_sum   = run_sum;
  assign q_job.row_end   = row_end;
  assign q_job.frame_end = frame_end;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    run_nxt = run_r;
    if (q_push) begin
      if (row_end) begin
        col_nxt = '0;
        run_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
        run_nxt = run_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      run_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      run_r <= run_nxt;
    end
  end

endmodule

// ===== hdl/iis_queue.sv =====
// short job queue between front and back ends
// depends on iis_pkg
module iis_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  iis_pkg::job_t push_job,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output iis_pkg::job_t pop_job
);

  iis_pkg::job_t            slot_r [iis_pkg::Q_DEPTH];
  logic [iis_pkg::Q_AW-1:0] wr_ptr_r;
  logic [iis_pkg::Q_AW-1:0] rd_ptr_r;
  logic [iis_pkg::Q_AW:0]   count_r;
  logic [iis_pkg::Q_AW:0]   count_nxt;

  assign ready   = (count_r != iis_pkg::Q_DEPTH[iis_pkg::Q_AW:0]);
  assign valid   = (count_r != '0);
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/iis_back.sv =====
// back end: line store read, area sum add, line store write and output register
// depends on iis_pkg, iis_if
module iis_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  iis_pkg::job_t q_job,
  output logic          q_pop,
  iis_sum_if.source     out_res
);

  logic [iis_pkg::SUM_W-1:0] line_mem [iis_pkg::MAX_WIDTH];
  logic [iis_pkg::SUM_W-1:0] rdata_r;

  logic                      b_valid_r;
  iis_pkg::job_t             b_job_r;
  logic                      fwd_r;
  logic [iis_pkg::SUM_W-1:0] fwd_data_r;
  logic [iis_pkg::SUM_W-1:0] above;
  logic [iis_pkg::SUM_W-1:0] b_sum;

  logic                      o_valid_r;
  logic [iis_pkg::SUM_W-1:0] o_sum_r;
  logic                      o_row_end_r;
  logic                      o_frame_end_r;

  logic                      o_load;

  always_comb begin
    if (b_job_r.first_row) begin
      above = '0;
    end else if (fwd_r) begin
      above = fwd_data_r;
    end else begin
      above = rdata_r;
    end
  end

  assign b_sum  = above + iis_pkg::SUM_W'(b_job_r.run_sum);
  assign o_load = b_valid_r && (!o_valid_r || out_res.ready);
  assign q_pop  = q_valid && (!b_valid_r || o_load);

  // line store, written as a word leaves the add stage
  always_ff @(posedge clk) begin
    if (o_load) begin
      line_mem[b_job_r.col] <= b_sum;
    end
    if (q_pop) begin
      rdata_r <= line_mem[q_job.col];
    end
  end

  // same-column write in the read cycle bypasses the store
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_job_r    <= q_job;
      fwd_r      <= o_load && (b_job_r.col == q_job.col);
      fwd_data_r <= b_sum;
    end
    if (o_load) begin
      o_sum_r       <= b_sum;
      o_row_end_r   <= b_job_r.row_end;
      o_frame_end_r <= b_job_r.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        b_valid_r <= 1'b1;
      end else if (o_load) begin
        b_valid_r <= 1'b0;
      end
      if (o_load) begin
        o_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  assign out_res.valid     = o_valid_r;
  assign out_res.area_sum  = o_sum_r;
  assign out_res.row_end   = o_row_end_r;
  assign out_res.frame_end = o_frame_end_r;

endmodule

// ===== hdl/integral_image_stream.sv =====
// top level of the streaming integral image block
// depends on iis_pkg, iis_if, iis_regs, iis_front, iis_queue, iis_back
//
// pixels arrive in raster order on in_pix (valid/ready, one 8-bit word per
// transfer); each one yields exactly one word on out_res: the summed-area
// value at that position plus row_end and frame_end flags. frame_width and
// frame_height sit at byte addresses 0 and 4 of the apb-style port; write
// them only while the block is idle. values of 0 count as 1, values above
// the maximum count as the maximum.
// throughput is one pixel per cycle while out_res takes results. a result
// moves from the queue, where the line store read is registered as it
// leaves, to the add stage and then the output register. the line store
// holds one sum per column; the first row of each image ignores what it
// reads there, so the store needs no clearing after reset.
// reset (synchronous, active low) zeroes the position counters and the row
// sum and loads both dimension registers with 1024. when the receiver holds
// ready low the result stays in the output register, the add stage and the
// two-entry queue fill up, and in_pix.ready drops once the queue is full.
module integral_image_stream (
  input  logic                       clk,
  input  logic                       rst_n,
  iis_pix_if.sink                    in_pix,
  iis_sum_if.source                  out_res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [iis_pkg::ADDR_W-1:0] paddr,
  input  logic [iis_pkg::DATA_W-1:0] pwdata,
  output logic [iis_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  iis_pkg::cfg_t cfg;
  logic          q_ready;
  logic          q_push;
  iis_pkg::job_t push_job;
  logic          q_valid;
  logic          q_pop;
  iis_pkg::job_t pop_job;

  iis_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  iis_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_pix  (in_pix),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  iis_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (pop_job)
  );

  iis_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

endmodule
